// ===== src/lbb_pkg.sv =====
package lbb_pkg;

  localparam int unsigned NumLedsDef = 8;
  localparam int unsigned TicksPerSecondDef = 1000;
  localparam int unsigned MaxOut = 8;
  localparam int unsigned PrescaleW = 10;

  localparam logic [31:0] Forever = 32'hffff_ffff;

  localparam logic [2:0] CmdTick    = 3'd0;
  localparam logic [2:0] CmdOff     = 3'd1;
  localparam logic [2:0] CmdOn      = 3'd2;
  localparam logic [2:0] CmdBlink   = 3'd3;
  localparam logic [2:0] CmdBreathe = 3'd4;

  localparam logic [1:0] ModeOff     = 2'd0;
  localparam logic [1:0] ModeOn      = 2'd1;
  localparam logic [1:0] ModeBlink   = 2'd2;
  localparam logic [1:0] ModeBreathe = 2'd3;

  localparam logic [2:0] RegLedCount    = 3'd0;
  localparam logic [2:0] RegActiveLow   = 3'd1;
  localparam logic [2:0] RegBlinkIntv   = 3'd2;
  localparam logic [2:0] RegBreathStep  = 3'd3;
  localparam logic [2:0] RegPwmTop      = 3'd4;

  localparam int unsigned ApbAddrW = 5;

  typedef struct packed {
    logic [3:0]  led_count;
    logic [7:0]  active_low_mask;
    logic [15:0] blink_interval_ms;
    logic [15:0] breath_step_ms;
    logic [15:0] pwm_top;
  } cfg_t;

endpackage

// ===== src/lbb_regs.sv =====
module lbb_regs
  import lbb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ApbAddrW-1:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_count         <= 4'd0;
      cfg_q.active_low_mask   <= 8'd0;
      cfg_q.blink_interval_ms <= 16'd500;
      cfg_q.breath_step_ms    <= 16'd10;
      cfg_q.pwm_top           <= 16'd100;
    end else if (wr_en) begin
      case (reg_idx)
        RegLedCount:   cfg_q.led_count         <= pwdata[3:0];
        RegActiveLow:  cfg_q.active_low_mask   <= pwdata[7:0];
        RegBlinkIntv:  cfg_q.blink_interval_ms <= pwdata[15:0];
        RegBreathStep: cfg_q.breath_step_ms    <= pwdata[15:0];
        RegPwmTop:     cfg_q.pwm_top           <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegLedCount:   prdata = {28'd0, cfg_q.led_count};
      RegActiveLow:  prdata = {24'd0, cfg_q.active_low_mask};
      RegBlinkIntv:  prdata = {16'd0, cfg_q.blink_interval_ms};
      RegBreathStep: prdata = {16'd0, cfg_q.breath_step_ms};
      RegPwmTop:     prdata = {16'd0, cfg_q.pwm_top};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== src/led_blink_breathe_controller_core.sv =====
// A mode command keeps busy high for one cycle and gives no result.
// A tick keeps busy high through a decode step and then, for each enabled LED,
// two steps on the one shared 32-bit subtractor (elapsed seconds, elapsed milliseconds)
// and an emit step. Each LED's result is registered there and strobed for one cycle.
// Results cannot be stalled by the receiver. Reset is asynchronous and active low; it
// clears the time counters and all LED state and loads the register defaults.
module led_blink_breathe_controller_core
  import lbb_pkg::*;
#(
  parameter int unsigned NUM_LEDS         = NumLedsDef,
  parameter int unsigned TICKS_PER_SECOND = TicksPerSecondDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          command_i,
  input  logic [2:0]          led_index_i,
  input  logic [31:0]         duration_s_i,
  output logic                result_valid_o,
  output logic [2:0]          out_led_o,
  output logic [1:0]          mode_now_o,
  output logic                pin_level_o,
  output logic [15:0]         duty_o,
  output logic                duty_update_o,
  output logic                last_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IdxW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned LimitC = (NUM_LEDS < MaxOut) ? NUM_LEDS : MaxOut;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StDecode = 2'd1;
  localparam logic [1:0] StElS    = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  cfg_t cfg;

  lbb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic [1:0]           state_q, state_d;
  logic                 elms_q, elms_d;
  logic [2:0]           cmd_q;
  logic [2:0]           idx_q;
  logic [31:0]          dur_q;
  logic [2:0]           cur_q, cur_d;
  logic [31:0]          diff_q;
  logic                 alive_q;
  logic [31:0]          ms_now_q;
  logic [PrescaleW-1:0] pre_q;
  logic [31:0]          sec_now_q;

  logic [1:0]  mode_q  [NUM_LEDS];
  logic        phase_q [NUM_LEDS];
  logic [31:0] sms_q   [NUM_LEDS];
  logic [31:0] ssec_q  [NUM_LEDS];
  logic [31:0] limit_q [NUM_LEDS];
  logic [15:0] duty_q  [NUM_LEDS];

  logic [IdxW-1:0] addr;
  logic [3:0]      n_lim;
  logic            is_last;
  logic            idx_ok;
  logic [1:0]      new_mode;
  logic [31:0]     sub_a, sub_b, sub_y;
  logic            accept;

  logic        inv;
  logic [1:0]  m_cur;
  logic        ph_cur;
  logic [15:0] d_cur;
  logic [1:0]  m_nxt;
  logic        ph_nxt;
  logic [15:0] d_nxt;
  logic        sms_upd;
  logic        pin;
  logic        upd;

  logic        rv_q;
  logic [2:0]  rled_q;
  logic [1:0]  rmode_q;
  logic        rpin_q;
  logic [15:0] rduty_q;
  logic        rupd_q;
  logic        rlast_q;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  assign n_lim   = (cfg.led_count > 4'(LimitC)) ? 4'(LimitC) : cfg.led_count;
  assign is_last = ({1'b0, cur_q} + 4'd1) == n_lim;
  assign idx_ok  = {29'd0, idx_q} < 32'(NUM_LEDS);
  assign addr    = (state_q == StDecode) ? IdxW'(idx_q) : IdxW'(cur_q);
  assign new_mode = 2'(cmd_q - 3'd1);

  // Shared subtractor: elapsed seconds first, then elapsed milliseconds.
  assign sub_a = elms_q ? ms_now_q : sec_now_q;
  assign sub_b = elms_q ? sms_q[addr] : ssec_q[addr];
  assign sub_y = sub_a - sub_b;

  assign m_cur  = mode_q[addr];
  assign ph_cur = phase_q[addr];
  assign d_cur  = duty_q[addr];
  assign inv    = cfg.active_low_mask[cur_q];

  always_comb begin
    m_nxt   = m_cur;
    ph_nxt  = ph_cur;
    d_nxt   = d_cur;
    sms_upd = 1'b0;
    pin     = inv;
    upd     = 1'b0;
    case (m_cur)
      ModeOff: begin
        ph_nxt = 1'b0;
      end
      ModeOn: begin
        pin    = !inv;
        ph_nxt = 1'b1;
      end
      ModeBlink: begin
        if (alive_q) begin
          pin = (!ph_cur) ^ inv;
          if (diff_q >= {16'd0, cfg.blink_interval_ms}) begin
            sms_upd = 1'b1;
            ph_nxt  = !ph_cur;
          end
        end else begin
          m_nxt = ModeOff;
        end
      end
      default: begin
        if (alive_q) begin
          if (diff_q >= {16'd0, cfg.breath_step_ms}) begin
            sms_upd = 1'b1;
            upd     = 1'b1;
            if (!ph_cur) begin
              d_nxt = (d_cur != 16'hffff) ? d_cur + 16'd1 : d_cur;
              if (d_nxt >= cfg.pwm_top) begin
                ph_nxt = 1'b1;
              end
            end else begin
              d_nxt = (d_cur != 16'd0) ? d_cur - 16'd1 : d_cur;
              if (d_nxt == 16'd0) begin
                ph_nxt = 1'b0;
              end
            end
          end
        end else begin
          m_nxt = ModeOff;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    elms_d  = elms_q;
    cur_d   = cur_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StDecode;
        end
      end
      StDecode: begin
        cur_d  = 3'd0;
        elms_d = 1'b0;
        if (cmd_q == CmdTick && n_lim != 4'd0) begin
          state_d = StElS;
        end else begin
          state_d = StIdle;
        end
      end
      StElS: begin
        if (!elms_q) begin
          elms_d = 1'b1;
        end else begin
          elms_d  = 1'b0;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (is_last) begin
          state_d = StIdle;
        end else begin
          cur_d   = cur_q + 3'd1;
          state_d = StElS;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      elms_q  <= 1'b0;
      cur_q   <= 3'd0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      elms_q  <= elms_d;
      cur_q   <= cur_d;
      rv_q    <= (state_q == StEmit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      idx_q <= led_index_i;
      dur_q <= duration_s_i;
    end
    if (state_q == StElS) begin
      diff_q <= sub_y;
      if (elms_q) begin
        alive_q <= diff_q <= limit_q[addr];
      end
    end
    if (state_q == StEmit) begin
      rled_q  <= cur_q;
      rmode_q <= m_nxt;
      rpin_q  <= (m_nxt == ModeBreathe) ? 1'b0 : pin;
      rduty_q <= (m_nxt == ModeBreathe) ? d_nxt : 16'd0;
      rupd_q  <= upd;
      rlast_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_now_q  <= 32'd0;
      pre_q     <= '0;
      sec_now_q <= 32'd0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        mode_q[i]  <= ModeOff;
        phase_q[i] <= 1'b0;
        sms_q[i]   <= 32'd0;
        ssec_q[i]  <= 32'd0;
        limit_q[i] <= Forever;
        duty_q[i]  <= 16'd0;
      end
    end else begin
      if (state_q == StDecode) begin
        if (cmd_q == CmdTick) begin
          ms_now_q <= ms_now_q + 32'd1;
          if ({1'b0, pre_q} + 11'd1 >= 11'(TICKS_PER_SECOND)) begin
            pre_q     <= '0;
            sec_now_q <= sec_now_q + 32'd1;
          end else begin
            pre_q <= pre_q + PrescaleW'(1);
          end
        end else if ((cmd_q == CmdOff || cmd_q == CmdOn || cmd_q == CmdBlink ||
                      cmd_q == CmdBreathe) && idx_ok && m_cur != new_mode) begin
          mode_q[addr] <= new_mode;
          sms_q[addr]  <= ms_now_q;
          ssec_q[addr] <= sec_now_q;
          limit_q[addr] <= (new_mode == ModeBlink || new_mode == ModeBreathe) ?
                           dur_q : Forever;
          if (new_mode == ModeBreathe) begin
            phase_q[addr] <= 1'b0;
            duty_q[addr]  <= 16'd0;
          end
        end
      end
      if (state_q == StEmit) begin
        mode_q[addr]  <= m_nxt;
        phase_q[addr] <= ph_nxt;
        duty_q[addr]  <= d_nxt;
        if (sms_upd) begin
          sms_q[addr] <= ms_now_q;
        end
      end
    end
  end

  assign result_valid_o = rv_q;
  assign out_led_o      = rled_q;
  assign mode_now_o     = rmode_q;
  assign pin_level_o    = rpin_q;
  assign duty_o         = rduty_q;
  assign duty_update_o  = rupd_q;
  assign last_o         = rlast_q;

endmodule
